### rtl/small_set_insert_remove_table_top_defines.svh
// Assertion macros for the small set table.
`ifndef SMALL_SET_INSERT_REMOVE_TABLE_TOP_DEFINES_SVH
`define SMALL_SET_INSERT_REMOVE_TABLE_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SSIRT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("set table assertion failed");

// next-cycle implication, checked out of reset
`define SSIRT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("set table assertion failed");

`endif

### rtl/ssirt_pkg.sv
// Types and constants shared by the small set table.
package ssirt_pkg;

	localparam int CAPACITY    = 16;
	localparam int VALUE_WIDTH = 16;
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int IDX_W       = $clog2(CAPACITY);
	localparam int ADDR_W      = 3;
	localparam int LIMIT_W     = 5;

	localparam logic [ADDR_W-3:0] REG_CAPACITY_LIMIT = '0;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] value;
		logic [3:0]  index;
	} ssirt_req_t;

	typedef struct packed {
		logic        was_present;
		logic        dropped_full;
		logic [4:0]  member_count;
		logic [15:0] read_value;
		logic        read_valid;
	} ssirt_rsp_t;

	// broadcast to every cell of the row
	typedef struct packed {
		logic                   do_add;
		logic                   do_rem;
		logic [VALUE_WIDTH-1:0] key;
	} ssirt_ctl_t;

endpackage

### rtl/ssirt_cell.sv
// One slot of the set row: holds a value, matches the key, shifts down on remove.
module ssirt_cell
	import ssirt_pkg::*;
(
	input  logic                   clk,
	input  ssirt_ctl_t             ctl,
	input  logic                   occ,
	input  logic                   occ_prev,
	input  logic                   shift_in,
	input  logic [VALUE_WIDTH-1:0] nxt_value,
	output logic [VALUE_WIDTH-1:0] value,
	output logic                   hit,
	output logic                   shift_out
);

	logic [VALUE_WIDTH-1:0] value_q;
	logic                   add_here;

	assign hit       = occ && (value_q == ctl.key);
	assign shift_out = shift_in | hit;
	// first free slot: previous one occupied, this one not
	assign add_here  = occ_prev & ~occ;
	assign value     = value_q;

	always_ff @(posedge clk) begin
		if (ctl.do_rem && shift_out) begin
			value_q <= nxt_value;
		end else if (ctl.do_add && add_here) begin
			value_q <= ctl.key;
		end
	end

endmodule

### rtl/small_set_insert_remove_table_top.sv
// Result strobe (done) is registered: it rises in the cycle after a request is accepted.
// Throughput: one request per cycle; busy is never raised.
// The rate is set by the row of slot cells, which compare the key and
// close a gap by shifting one place in the same cycle.
// Reset empties the set and sets capacity_limit to 16; slot contents stay
// undefined until written. The receiver cannot stall.
`include "small_set_insert_remove_table_top_defines.svh"

module small_set_insert_remove_table_top
	import ssirt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ssirt_req_t        req,
	output logic              done,
	output ssirt_rsp_t        rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [CNT_W-1:0]       count_q, count_nxt;
	logic [LIMIT_W-1:0]     limit_q;
	logic                   done_q;
	ssirt_rsp_t             rsp_q, rsp_d;

	logic                   accept;
	logic [31:0]            key_ext;
	ssirt_ctl_t             ctl;
	logic [CAPACITY-1:0]    occ, hit, shift_chain;
	logic [VALUE_WIDTH-1:0] slot_vals [CAPACITY];
	logic                   present, room;
	logic [15:0]            count_ext, eff_limit, idx_ext;
	logic                   rd_ok;
	logic [VALUE_WIDTH-1:0] rd_val;
	logic [31:0]            rd_ext;
	logic [15:0]            cnt_out_ext;
	logic                   reg_sel;

	assign busy   = 1'b0;
	assign accept = start & ~busy;
	assign pready = 1'b1;

	// configuration port
	assign reg_sel = (paddr[ADDR_W-1:2] == REG_CAPACITY_LIMIT);
	assign prdata  = reg_sel ? 32'(limit_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	// key and occupancy
	assign key_ext = 32'(req.value);

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			occ[i] = (32'(i) < 32'(count_q));
		end
	end

	assign present   = |hit;
	assign count_ext = 16'(count_q);
	assign eff_limit = (16'(limit_q) > 16'(CAPACITY)) ? 16'(CAPACITY) : 16'(limit_q);
	assign room      = count_ext < eff_limit;

	assign ctl.key    = key_ext[VALUE_WIDTH-1:0];
	assign ctl.do_add = accept && (req.op == OP_ADD) && !present && room;
	assign ctl.do_rem = accept && (req.op == OP_REMOVE) && present;

	// row of slot cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                   occ_prev_w, shift_in_w;
		logic [VALUE_WIDTH-1:0] nxt_w;

		if (i == 0) begin : g_first
			assign occ_prev_w = 1'b1;
			assign shift_in_w = 1'b0;
		end else begin : g_rest
			assign occ_prev_w = occ[i-1];
			assign shift_in_w = shift_chain[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign nxt_w = slot_vals[i];
		end else begin : g_inner
			assign nxt_w = slot_vals[i+1];
		end

		ssirt_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occ       (occ[i]),
			.occ_prev  (occ_prev_w),
			.shift_in  (shift_in_w),
			.nxt_value (nxt_w),
			.value     (slot_vals[i]),
			.hit       (hit[i]),
			.shift_out (shift_chain[i])
		);
	end

	// count update
	always_comb begin
		count_nxt = count_q;
		if (accept) begin
			unique case (req.op)
				OP_ADD:    if (ctl.do_add) count_nxt = count_q + 1'b1;
				OP_REMOVE: if (ctl.do_rem) count_nxt = count_q - 1'b1;
				OP_CLEAR:  count_nxt = '0;
				OP_READ:   count_nxt = count_q;
				default:   count_nxt = count_q;
			endcase
		end
	end

	// read path
	assign idx_ext = 16'(req.index);
	assign rd_ok   = (req.op == OP_READ) && (idx_ext < count_ext) && (idx_ext < 16'(CAPACITY));
	assign rd_val  = slot_vals[idx_ext[IDX_W-1:0]];
	assign rd_ext  = 32'(rd_val);

	assign cnt_out_ext = 16'(count_nxt);

	always_comb begin
		rsp_d              = '0;
		rsp_d.was_present  = ((req.op == OP_ADD) || (req.op == OP_REMOVE)) && present;
		rsp_d.dropped_full = (req.op == OP_ADD) && !present && !room;
		rsp_d.member_count = cnt_out_ext[4:0];
		rsp_d.read_valid   = rd_ok;
		rsp_d.read_value   = rd_ok ? rd_ext[15:0] : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			done_q  <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`SSIRT_ASSERT_NEXT(a_done_follows_req, accept, done)
	`SSIRT_ASSERT_NEXT(a_no_spurious_done, !accept, !done)
	`SSIRT_ASSERT_NOW(a_distinct_entries, 1'b1, $onehot0(hit))
	`SSIRT_ASSERT_NOW(a_count_in_range, 1'b1, 32'(count_q) <= 32'(CAPACITY))

endmodule
